// ===== src/wpsp_pkg.sv =====
// Shared types, sizes and codes of the wildcard pattern scan and patch block.
`default_nettype none

package wpsp_pkg;

  localparam int unsigned PATTERN_MAX = 512;
  localparam int unsigned OFFSET_BITS = 32;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned SLOT_W    = 9;
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned OFFSET_W  = 32;

  localparam int unsigned IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int unsigned WIDE_W = (LEN_W > SLOT_W) ? LEN_W : SLOT_W;

  // Fan-in of each level of the mismatch reduction tree.
  localparam int unsigned GROUP = 8;
  localparam int unsigned L1_N  = (PATTERN_MAX + GROUP - 1) / GROUP;
  localparam int unsigned L2_N  = (L1_N + GROUP - 1) / GROUP;

  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [CFG_W-1:0]       cfg_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [WIDE_W-1:0]      wide_t;
  typedef logic [OFFSET_BITS-1:0] cnt_t;
  typedef logic [OFFSET_W-1:0]    offset_t;
  typedef logic [L1_N*GROUP-1:0]  l1_pad_t;
  typedef logic [L2_N*GROUP-1:0]  l2_pad_t;

  // A pattern byte of this value matches any data byte.
  localparam byte_t WILDCARD = 8'h00;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_PATTERN = 3'd0,
    ACT_LOAD_REPLACE = 3'd1,
    ACT_DATA         = 3'd2,
    ACT_DRAIN        = 3'd3,
    ACT_RESTART      = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 1'b0,
    REG_REPLACE_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE1,
    ST_REDUCE2,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SLOT_W-1:0]   slot;
    logic [BYTE_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic                last;
  } out_item_t;

  // Broadcast from the controller to every cell of the window chain.
  typedef struct packed {
    logic  pop;
    logic  push;
    idx_t  push_pos;
    byte_t data;
    logic  pat_we;
    logic  rep_we;
    slot_t slot;
    byte_t load_val;
    logic  patch;
    len_t  patch_len;
    len_t  cmp_len;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/wpsp_cell.sv =====
// One window cell: a window byte, its pattern byte and its replacement byte.
`default_nettype none

module wpsp_cell (
  input  wire logic                clk_i,
  input  wire wpsp_pkg::idx_t      idx_i,
  input  wire wpsp_pkg::cell_ctrl_t ctrl_i,
  input  wire wpsp_pkg::byte_t     next_win_i,
  output wpsp_pkg::byte_t          win_o,
  output logic                     mismatch_o
);

  wpsp_pkg::byte_t win_q, win_d;
  wpsp_pkg::byte_t pat_q, pat_d;
  wpsp_pkg::byte_t rep_q, rep_d;

  always_comb begin
    win_d = win_q;
    // A pop moves every byte one cell toward the head.
    if (ctrl_i.pop) begin
      win_d = next_win_i;
    end
    if (ctrl_i.push && (idx_i == ctrl_i.push_pos)) begin
      win_d = ctrl_i.data;
    end
    if (ctrl_i.patch && (wpsp_pkg::len_t'(idx_i) < ctrl_i.patch_len)) begin
      win_d = rep_q;
    end
  end

  always_comb begin
    pat_d = pat_q;
    rep_d = rep_q;
    if (ctrl_i.pat_we &&
        (wpsp_pkg::wide_t'(idx_i) == wpsp_pkg::wide_t'(ctrl_i.slot))) begin
      pat_d = ctrl_i.load_val;
    end
    if (ctrl_i.rep_we &&
        (wpsp_pkg::wide_t'(idx_i) == wpsp_pkg::wide_t'(ctrl_i.slot))) begin
      rep_d = ctrl_i.load_val;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    pat_q <= pat_d;
    rep_q <= rep_d;
  end

  assign win_o      = win_q;
  assign mismatch_o = (wpsp_pkg::len_t'(idx_i) < ctrl_i.cmp_len) &&
                      (pat_q != wpsp_pkg::WILDCARD) && (pat_q != win_q);

endmodule

`default_nettype wire

// ===== src/wpsp_mismatch_tree.sv =====
// Two registered OR levels that reduce the per-cell mismatch flags.
`default_nettype none

module wpsp_mismatch_tree (
  input  wire logic                               clk_i,
  input  wire logic [wpsp_pkg::PATTERN_MAX-1:0]   mis_i,
  output logic                                    any_o
);

  wpsp_pkg::l1_pad_t              mis_pad;
  logic [wpsp_pkg::L1_N-1:0]      l1_q, l1_d;
  wpsp_pkg::l2_pad_t              l1_pad;
  logic [wpsp_pkg::L2_N-1:0]      l2_q, l2_d;

  assign mis_pad = wpsp_pkg::l1_pad_t'(mis_i);
  assign l1_pad  = wpsp_pkg::l2_pad_t'(l1_q);

  always_comb begin
    for (int g = 0; g < wpsp_pkg::L1_N; g++) begin
      l1_d[g] = |mis_pad[g*wpsp_pkg::GROUP +: wpsp_pkg::GROUP];
    end
  end

  always_comb begin
    for (int g = 0; g < wpsp_pkg::L2_N; g++) begin
      l2_d[g] = |l1_pad[g*wpsp_pkg::GROUP +: wpsp_pkg::GROUP];
    end
  end

  always_ff @(posedge clk_i) begin
    l1_q <= l1_d;
    l2_q <= l2_d;
  end

  assign any_o = |l2_q;

endmodule

`default_nettype wire

// ===== src/wpsp_ctrl.sv =====
// Controller: item decode, fill and offset counters, match state and result register.
`default_nettype none

module wpsp_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire wpsp_pkg::in_item_t       in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output wpsp_pkg::out_item_t           out_data_o,
  input  wire logic [wpsp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic                     cfg_we_i,
  input  wire wpsp_pkg::cfg_t           cfg_wdata_i,
  input  wire wpsp_pkg::byte_t          head_i,
  input  wire logic                     any_mis_i,
  output wpsp_pkg::cell_ctrl_t          cell_ctrl_o
);

  wpsp_pkg::state_e    state_q, state_d;
  wpsp_pkg::len_t      len_q, len_d;
  wpsp_pkg::cfg_t      rlen_q, rlen_d;
  wpsp_pkg::len_t      fill_q, fill_d;
  wpsp_pkg::cnt_t      cnt_q, cnt_d;
  logic                found_q, found_d;
  wpsp_pkg::cnt_t      pos_q, pos_d;
  logic                pend_q, pend_d;
  wpsp_pkg::byte_t     pend_byte_q, pend_byte_d;
  wpsp_pkg::len_t      cmp_len_q, cmp_len_d;
  wpsp_pkg::len_t      patch_len_q, patch_len_d;
  logic                out_valid_q, out_valid_d;
  wpsp_pkg::out_item_t out_data_q, out_data_d;

  logic                accept;
  logic                is_pat, is_rep, is_data, is_drain, is_restart;
  logic                leaving;
  wpsp_pkg::len_t      fill_push;
  logic                need_cmp;
  logic                data_cmp;
  logic                emit;
  logic                emit_last;
  wpsp_pkg::byte_t     emit_byte;

  assign in_ready_o = (state_q == wpsp_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    is_pat     = 1'b0;
    is_rep     = 1'b0;
    is_data    = 1'b0;
    is_drain   = 1'b0;
    is_restart = 1'b0;
    unique case (wpsp_pkg::action_e'(in_data_i.action))
      wpsp_pkg::ACT_LOAD_PATTERN: is_pat     = 1'b1;
      wpsp_pkg::ACT_LOAD_REPLACE: is_rep     = 1'b1;
      wpsp_pkg::ACT_DATA:         is_data    = 1'b1;
      wpsp_pkg::ACT_DRAIN:        is_drain   = 1'b1;
      wpsp_pkg::ACT_RESTART:      is_restart = 1'b1;
      default: ;
    endcase
  end

  // A full window loses its oldest byte before the new byte enters.
  assign leaving   = (fill_q >= len_q);
  assign fill_push = leaving ? fill_q : (fill_q + wpsp_pkg::len_t'(1));
  assign need_cmp  = !found_q && (fill_push == len_q);
  assign data_cmp  = accept && is_data && need_cmp;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wpsp_pkg::ST_IDLE: begin
        if (data_cmp) begin
          state_d = wpsp_pkg::ST_REDUCE1;
        end
      end
      wpsp_pkg::ST_REDUCE1: state_d = wpsp_pkg::ST_REDUCE2;
      wpsp_pkg::ST_REDUCE2: state_d = wpsp_pkg::ST_DECIDE;
      wpsp_pkg::ST_DECIDE:  state_d = wpsp_pkg::ST_IDLE;
      default:              state_d = wpsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    len_d       = len_q;
    rlen_d      = rlen_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    found_d     = found_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    pend_byte_d = pend_byte_q;
    cmp_len_d   = cmp_len_q;
    patch_len_d = patch_len_q;
    emit        = 1'b0;
    emit_last   = 1'b0;
    emit_byte   = head_i;

    cell_ctrl_o           = '0;
    cell_ctrl_o.data      = in_data_i.value;
    cell_ctrl_o.slot      = in_data_i.slot;
    cell_ctrl_o.load_val  = in_data_i.value;
    cell_ctrl_o.patch_len = patch_len_q;
    cell_ctrl_o.cmp_len   = cmp_len_q;

    if (cfg_we_i) begin
      unique case (wpsp_pkg::cfg_reg_e'(cfg_idx_i))
        wpsp_pkg::REG_PATTERN_LENGTH: begin
          if (cfg_wdata_i == '0) begin
            len_d = wpsp_pkg::len_t'(1);
          end else if (cfg_wdata_i > wpsp_pkg::PATTERN_MAX) begin
            len_d = wpsp_pkg::len_t'(wpsp_pkg::PATTERN_MAX);
          end else begin
            len_d = wpsp_pkg::len_t'(cfg_wdata_i);
          end
        end
        wpsp_pkg::REG_REPLACE_LENGTH: rlen_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (accept) begin
      if (is_pat) begin
        cell_ctrl_o.pat_we = 1'b1;
      end
      if (is_rep) begin
        cell_ctrl_o.rep_we = 1'b1;
      end
      if (is_data) begin
        cell_ctrl_o.push     = 1'b1;
        cell_ctrl_o.pop      = leaving;
        cell_ctrl_o.push_pos = leaving ? wpsp_pkg::idx_t'(fill_q - wpsp_pkg::len_t'(1))
                                       : wpsp_pkg::idx_t'(fill_q);
        fill_d    = fill_push;
        cmp_len_d = len_q;
        patch_len_d = (rlen_q < len_q) ? wpsp_pkg::len_t'(rlen_q) : len_q;
        if (cnt_q != '1) begin
          cnt_d = cnt_q + wpsp_pkg::cnt_t'(1);
        end
        if (need_cmp) begin
          // The leaving byte waits until the compare has settled the found flag.
          pend_d      = leaving;
          pend_byte_d = head_i;
        end else begin
          emit = leaving;
        end
      end
      if (is_drain && (fill_q != '0)) begin
        cell_ctrl_o.pop = 1'b1;
        fill_d          = fill_q - wpsp_pkg::len_t'(1);
        emit            = 1'b1;
        emit_last       = (fill_q == wpsp_pkg::len_t'(1));
      end
      if (is_restart) begin
        fill_d  = '0;
        cnt_d   = '0;
        found_d = 1'b0;
        pos_d   = '0;
      end
    end

    if (state_q == wpsp_pkg::ST_DECIDE) begin
      if (!any_mis_i) begin
        found_d = 1'b1;
        pos_d   = (cnt_q >= wpsp_pkg::cnt_t'(cmp_len_q))
                ? (cnt_q - wpsp_pkg::cnt_t'(cmp_len_q)) : '0;
        cell_ctrl_o.patch = 1'b1;
      end
      if (pend_q) begin
        emit      = 1'b1;
        emit_byte = pend_byte_q;
        pend_d    = 1'b0;
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    if (emit) begin
      out_valid_d             = 1'b1;
      out_data_d.out_byte     = emit_byte;
      out_data_d.found        = found_d;
      out_data_d.match_offset = wpsp_pkg::offset_t'(pos_d);
      out_data_d.last         = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wpsp_pkg::ST_IDLE;
      len_q       <= wpsp_pkg::len_t'(1);
      rlen_q      <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rlen_q      <= rlen_d;
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      pos_q       <= pos_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
    cmp_len_q   <= cmp_len_d;
    patch_len_q <= patch_len_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== src/wildcard_pattern_scan_and_patch_top.sv =====
// Top level of the wildcard byte pattern scan and patch block.
`default_nettype none

// The window is a chain of cells, one per pattern position; each cell holds its
// window byte, pattern byte and replacement byte, and the window shifts one cell
// toward the head on every byte that leaves. Pattern and replacement loads, drains,
// restarts and data bytes that do not complete a compare are handled as they are taken. A
// data byte that brings the window to pattern_length bytes while no match has been found
// enters the window, passes the two registered levels of the mismatch OR tree, and is
// then decided, patched and its result released; no new item is taken meanwhile. Every
// result passes through a single output register, and a new item is taken only when no
// compare is in progress and that register is empty or is being read in the same cycle. No clearing pass follows reset.
module wildcard_pattern_scan_and_patch_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire wpsp_pkg::in_item_t                  in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output wpsp_pkg::out_item_t                      out_data_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [wpsp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [wpsp_pkg::CFG_W-1:0]          cfg_wdata_i
);

  wpsp_pkg::cell_ctrl_t             cell_ctrl;
  wpsp_pkg::byte_t                  win      [wpsp_pkg::PATTERN_MAX];
  wpsp_pkg::byte_t                  next_win [wpsp_pkg::PATTERN_MAX];
  logic [wpsp_pkg::PATTERN_MAX-1:0] mis;
  logic                             any_mis;

  wpsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (win[0]),
    .any_mis_i   (any_mis),
    .cell_ctrl_o (cell_ctrl)
  );

  for (genvar k = 0; k < wpsp_pkg::PATTERN_MAX; k++) begin : g_cell
    if (k == wpsp_pkg::PATTERN_MAX - 1) begin : g_tail
      assign next_win[k] = '0;
    end else begin : g_link
      assign next_win[k] = win[k+1];
    end

    wpsp_cell u_cell (
      .clk_i      (clk_i),
      .idx_i      (wpsp_pkg::idx_t'(k)),
      .ctrl_i     (cell_ctrl),
      .next_win_i (next_win[k]),
      .win_o      (win[k]),
      .mismatch_o (mis[k])
    );
  end

  wpsp_mismatch_tree u_tree (
    .clk_i (clk_i),
    .mis_i (mis),
    .any_o (any_mis)
  );

endmodule

`default_nettype wire
